### rtl/core/lacgs_pkg.sv
// Package: constants, types and gain math for the lookahead compressor gain stage.
package lacgs_pkg;

    localparam int MAX_DELAY_DEF   = 16384;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd7;

    // log2(10)/20 in Q0.16, exp2 polynomial terms
    localparam logic [13:0] LOG2_DB_K = 14'd10885;
    localparam logic [15:0] EXP_C1    = 16'd43028;
    localparam logic [14:0] EXP_C2    = 15'd22508;
    localparam logic [16:0] WET_ONE   = 17'd65536;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ENV, ST_RED, ST_GAIN1, ST_GAIN2, ST_GAIN3,
        ST_WETL, ST_WETR, ST_MIXL, ST_MIXR, ST_OUT
    } t_state;

endpackage

### rtl/core/lacgs_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface lacgs_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [14:0]            level_db;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    modport source (output valid, level_db, left_in, right_in, input ready);
    modport sink   (input valid, level_db, left_in, right_in, output ready);
endinterface

interface lacgs_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic signed [14:0]            reduction_db;
    modport source (output valid, left_out, right_out, reduction_db, input ready);
    modport sink   (input valid, left_out, right_out, reduction_db, output ready);
endinterface

interface lacgs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/lacgs_delay.sv
// Stereo delay line memory; its user clears it after reset through the write port.
module lacgs_delay
    import lacgs_pkg::*;
#(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW = $clog2(MAX_DELAY)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_wl,
    input  logic signed [SAMPLE_BITS-1:0] i_wr,
    input  logic [AW-1:0]                 i_raddr,
    output logic signed [SAMPLE_BITS-1:0] o_rl,
    output logic signed [SAMPLE_BITS-1:0] o_rr
);
    logic [2*SAMPLE_BITS-1:0] mem [MAX_DELAY];
    logic [2*SAMPLE_BITS-1:0] r_rd;

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wl, i_wr};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rl = r_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign o_rr = r_rd[SAMPLE_BITS-1:0];
endmodule

### rtl/core/lookahead_compressor_gain_stage.sv
// Top level: compressor envelope, gain computer, exp2 gain, lookahead delay and mix.
// Usage:
//  i_in carries one word per sample: level_db (signed Q7.8 dB) and a stereo pair.
//  o_out carries one word per input: mixed left/right and reduction_db.
//  i_cfg writes register index/data; write only while the block is idle.
// Timing:
//  An item is accepted in ST_IDLE and runs through a sequencer that shares
//  one multiplier step per state: envelope, reduction, three exp2 steps,
//  two wet products and two mix products. The result word is then offered
//  on o_out in ST_OUT; the next item is taken the cycle after the result
//  word is taken, so no new item is taken before the last result has
//  been taken.
// Reset:
//  Configuration registers return to defaults and the envelope to 0 dB.
//  The delay memory is then cleared one entry a cycle, all MAX_DELAY (16384
//  by default) entries, with no item accepted; configuration writes are taken.
// Stall:
//  The result word holds on o_out until taken; no new item enters meanwhile.
module lookahead_compressor_gain_stage
    import lacgs_pkg::*;
#(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lacgs_in_if.sink    i_in,
    lacgs_out_if.source o_out,
    lacgs_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(MAX_DELAY);
    localparam int SB = SAMPLE_BITS;
    localparam int WW = SB + 6;     // wet product: sample times gain below 2^6
    localparam int MW = SB + 24;    // mix sum before rounding
    localparam logic [13:0] LA_MAX14 = (MAX_DELAY - 1 > 16383) ? 14'd16383
                                                               : 14'(MAX_DELAY - 1);

    // configuration registers
    logic signed [14:0] r_thr;
    logic [15:0] r_ratio, r_att, r_rel;
    logic [13:0] r_depth;
    logic [12:0] r_makeup;
    logic [16:0] r_wet;
    logic [13:0] r_la;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= -15'sd5120; r_ratio <= 16'd49152; r_att <= 16'd65000;
            r_rel <= 16'd65400; r_depth <= 14'd6144; r_makeup <= '0;
            r_wet <= WET_ONE; r_la <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THRESHOLD: r_thr    <= i_cfg.data[14:0];
                REG_RATIO:     r_ratio  <= i_cfg.data[15:0];
                REG_ATTACK:    r_att    <= i_cfg.data[15:0];
                REG_RELEASE:   r_rel    <= i_cfg.data[15:0];
                REG_DEPTH:     r_depth  <= i_cfg.data[13:0];
                REG_MAKEUP:    r_makeup <= i_cfg.data[12:0];
                REG_WET:       r_wet    <= i_cfg.data;
                REG_LOOKAHEAD: r_la     <= i_cfg.data[13:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    t_state r_st, n_st;
    logic [AW-1:0] r_wp, r_clr;
    logic signed [15:0] r_env;
    logic signed [14:0] r_lvl, r_red;
    logic signed [SB-1:0] r_l, r_r, r_dl, r_dr, r_ol, r_or;
    logic signed [WW-1:0] r_wl, r_wr;
    logic [16:0] r_f;
    logic signed [7:0] r_ip;
    logic [16:0] r_m;
    logic [33:0] r_gain;

    // delay memory: clear pass, then write current sample and read delayed one
    // (read is issued in ST_RED, the state after the write in ST_ENV, so zero
    // delay returns the current sample)
    logic [AW-1:0] la_clip, rd_addr, waddr;
    logic we;
    logic signed [SB-1:0] mem_l, mem_r;
    logic [13:0] la_sat;
    assign la_sat  = (r_la > LA_MAX14) ? LA_MAX14 : r_la;
    assign la_clip = AW'(la_sat);
    assign rd_addr = r_wp - AW'(1) - la_clip;
    assign we      = (r_st == ST_CLEAR) || (r_st == ST_ENV);
    assign waddr   = (r_st == ST_CLEAR) ? r_clr : r_wp;

    lacgs_delay #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SAMPLE_BITS)) u_delay (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wl   ((r_st == ST_CLEAR) ? '0 : r_l),
        .i_wr   ((r_st == ST_CLEAR) ? '0 : r_r),
        .i_raddr(rd_addr),
        .o_rl   (mem_l),
        .o_rr   (mem_r)
    );

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR: if (r_clr == AW'(MAX_DELAY - 1)) n_st = ST_IDLE;
            ST_IDLE:  if (i_in.valid) n_st = ST_ENV;
            ST_ENV:   n_st = ST_RED;
            ST_RED:   n_st = ST_GAIN1;
            ST_GAIN1: n_st = ST_GAIN2;
            ST_GAIN2: n_st = ST_GAIN3;
            ST_GAIN3: n_st = ST_WETL;
            ST_WETL:  n_st = ST_WETR;
            ST_WETR:  n_st = ST_MIXL;
            ST_MIXL:  n_st = ST_MIXR;
            ST_MIXR:  n_st = ST_OUT;
            ST_OUT:   if (o_out.ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    assign i_in.ready   = (r_st == ST_IDLE);
    assign o_out.valid  = (r_st == ST_OUT);
    assign o_out.left_out     = r_ol;
    assign o_out.right_out    = r_or;
    assign o_out.reduction_db = r_red;

    // envelope step
    logic signed [17:0] coef, coef_c;
    logic signed [33:0] env_sum;
    logic signed [15:0] env_n;
    assign coef    = (r_lvl > r_env) ? $signed({2'b0, r_att}) : $signed({2'b0, r_rel});
    assign coef_c  = 18'sd65536 - coef;
    assign env_sum = 34'(coef) * 34'(r_env) + 34'(coef_c) * 34'(r_lvl) + 34'sd32768;
    assign env_n   = 16'(env_sum >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0; r_wp <= '0; r_env <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_st == ST_ENV)   r_wp  <= r_wp + 1'b1;
            if (r_st == ST_ENV)   r_env <= env_n;
        end
    end

    // reduction step
    logic signed [17:0] over;
    logic [33:0] rprod;
    logic [17:0] rq;
    logic [13:0] red_mag;
    assign over    = 18'(r_env) - 18'(r_thr);
    assign rprod   = 34'(over[16:0]) * 34'(r_ratio) + 34'd32768;
    assign rq      = 18'(rprod >> 16);
    assign red_mag = (over <= 0) ? 14'd0 : ((rq > 18'(r_depth)) ? r_depth : rq[13:0]);

    // gain steps: polynomial term registered in ST_GAIN2, mantissa in ST_GAIN3
    logic signed [15:0] dsum;
    logic signed [31:0] eprod, e;
    logic [33:0] p2;
    logic [16:0] fpoly;
    logic [33:0] p3;
    assign dsum  = 16'(r_red) + 16'($signed({1'b0, r_makeup}));
    assign eprod = 32'(dsum) * 32'($signed({1'b0, LOG2_DB_K})) + 32'sd128;
    assign e     = eprod >>> 8;
    assign p2    = 34'(r_f) * 34'(EXP_C2);
    assign fpoly = 17'(EXP_C1) + 17'(p2 >> 16);
    assign p3    = 34'(r_f) * 34'(r_m);

    // wet and mix steps share a signed multiplier pattern
    logic signed [SB+35:0] wprod;
    logic signed [SB:0]    wsrc;
    logic [16:0] wm, dm;
    logic signed [MW-1:0]  mix_sum;
    logic signed [WW-1:0]  wsel;
    logic signed [SB-1:0]  dsel;
    logic signed [SB+7:0]  mix_r;
    localparam logic signed [SB+7:0] SMAX = (SB+8)'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [SB+7:0] SMIN = -SMAX - 1;
    assign wsrc    = (r_st == ST_WETL) ? (SB+1)'(r_dl) : (SB+1)'(r_dr);
    assign wprod   = (SB+36)'(wsrc) * $signed({2'b0, r_gain}) + (SB+36)'(33'sd32768);
    assign wm      = (r_wet > WET_ONE) ? WET_ONE : r_wet;
    assign dm      = WET_ONE - wm;
    assign wsel    = (r_st == ST_MIXL) ? r_wl : r_wr;
    assign dsel    = (r_st == ST_MIXL) ? r_l : r_r;
    assign mix_sum = MW'(wsel) * MW'($signed({1'b0, wm}))
                   + MW'(dsel) * MW'($signed({1'b0, dm})) + MW'(32768);
    assign mix_r   = (SB+8)'(mix_sum >>> 16);

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_lvl <= i_in.level_db; r_l <= i_in.left_in; r_r <= i_in.right_in;
            end
            ST_RED: r_red <= -$signed({1'b0, red_mag});
            ST_GAIN1: begin
                r_dl <= mem_l; r_dr <= mem_r;
                r_ip <= 8'(e >>> 16);
                r_f  <= {1'b0, e[15:0]};
            end
            ST_GAIN2: r_m <= fpoly;
            ST_GAIN3: begin
                r_gain <= (r_ip >= 0) ? (34'(32'd65536 + 32'(p3 >> 16)) << r_ip[4:0])
                                     : (34'(32'd65536 + 32'(p3 >> 16)) >> 5'(-r_ip));
            end
            ST_WETL: r_wl <= WW'(wprod >>> 16);
            ST_WETR: r_wr <= WW'(wprod >>> 16);
            ST_MIXL: r_ol <= (mix_r > SMAX) ? SB'(SMAX) : (mix_r < SMIN) ? SB'(SMIN) : SB'(mix_r);
            ST_MIXR: r_or <= (mix_r > SMAX) ? SB'(SMAX) : (mix_r < SMIN) ? SB'(SMIN) : SB'(mix_r);
            default: ;
        endcase
    end

    // checks
    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !i_in.ready) else $error("ready outside idle");
    a_red_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_red <= 0)) else $error("positive reduction");
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_MIXR) |=> o_out.valid) else $error("result lost");
endmodule
